// File: rtl/q2r_pkg.sv
// ----------------------------------------------------------------------------
// q2r_pkg: shared types and constants
// Entry tables, widths and the sideband record of the quaternion to rotation
// gradient core.
// ----------------------------------------------------------------------------
package q2r_pkg;

	localparam int QW      = 16;  // quaternion component, Q2.14
	localparam int GW      = 24;  // gradient, Q8.16
	localparam int ENT_W   = 4;   // entry counter
	localparam int DIV_N   = 25;  // quotient bits per divider lane
	localparam int GDIV_W  = 66;  // gradient divider remainder width
	localparam int RDIV_W  = 35;  // rotation divider remainder width

	localparam logic [ENT_W-1:0] LAST_ENT = 4'd8;

	// component codes
	localparam logic [1:0] CX = 2'd0;
	localparam logic [1:0] CY = 2'd1;
	localparam logic [1:0] CZ = 2'd2;
	localparam logic [1:0] CW = 2'd3;

	// register map (word index taken from paddr[2])
	localparam logic REG_GRAD_EN = 1'b0;

	// dN/dc_j = +/- 2 * c[DSEL], one row per entry, columns x y z w
	localparam logic [1:0] DSEL [9][4] = '{
		'{CX, CY, CZ, CW},
		'{CY, CX, CW, CZ},
		'{CZ, CW, CX, CY},
		'{CY, CX, CW, CZ},
		'{CX, CY, CZ, CW},
		'{CW, CZ, CY, CX},
		'{CZ, CW, CX, CY},
		'{CW, CZ, CY, CX},
		'{CX, CY, CZ, CW}
	};
	localparam logic DNEG [9][4] = '{
		'{1'b0, 1'b1, 1'b1, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b1, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b1, 1'b1},
		'{1'b1, 1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b1},
		'{1'b1, 1'b1, 1'b0, 1'b0}
	};
	localparam logic [1:0] ROW_OF [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
	localparam logic [1:0] COL_OF [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
		logic       last;
	} meta_t;

	typedef struct packed {
		logic       valid;
		meta_t      meta;
		logic       zero;
		logic       rneg;
		logic [3:0] gneg;
		logic [3:0] ovf;
	} side_t;

endpackage

// File: rtl/q2r_quat_if.sv
// ----------------------------------------------------------------------------
// q2r_quat_if: quaternion channel
// Valid/ready channel carrying one quaternion per transaction.
// ----------------------------------------------------------------------------
interface q2r_quat_if;
	import q2r_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;
	logic signed [QW-1:0] quat_w;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// File: rtl/q2r_entry_if.sv
// ----------------------------------------------------------------------------
// q2r_entry_if: matrix entry channel
// Valid/ready channel carrying one matrix entry and its gradient.
// ----------------------------------------------------------------------------
interface q2r_entry_if;
	import q2r_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           row_index;
	logic [1:0]           col_index;
	logic signed [QW-1:0] rot_entry;
	logic signed [GW-1:0] grad_x;
	logic signed [GW-1:0] grad_y;
	logic signed [GW-1:0] grad_z;
	logic signed [GW-1:0] grad_w;
	logic                 zero_norm;
	logic                 last_entry;

	modport source (output valid, row_index, col_index, rot_entry, grad_x, grad_y, grad_z,
		grad_w, zero_norm, last_entry, input ready);
	modport sink   (input valid, row_index, col_index, rot_entry, grad_x, grad_y, grad_z,
		grad_w, zero_norm, last_entry, output ready);
endinterface

// File: rtl/q2r_div.sv
// ----------------------------------------------------------------------------
// q2r_div: pipelined restoring divider
// One quotient bit per stage, MSB first; the initial remainder must be below
// the divisor. Tail bits are shifted in as the low dividend bits.
// ----------------------------------------------------------------------------
module q2r_div #(
	parameter int W = 66,
	parameter int N = 25
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-1:0] rem_in,
	input  logic [N-1:0] tail_in,
	input  logic [W-1:0] den_in,
	output logic [N-1:0] quot
);

	logic [W-1:0] rem_s  [N+1];
	logic [W-1:0] den_s  [N+1];
	logic [N-1:0] tail_s [N+1];
	logic [N-1:0] quot_s [N+1];

	assign rem_s[0]  = rem_in;
	assign den_s[0]  = den_in;
	assign tail_s[0] = tail_in;
	assign quot_s[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [W-1:0] trial;
		logic         ge;

		assign trial = {rem_s[k][W-2:0], tail_s[k][N-1]};
		assign ge    = (trial >= den_s[k]);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge ? (trial - den_s[k]) : trial;
				den_s[k+1]  <= den_s[k];
				tail_s[k+1] <= tail_s[k] << 1;
				quot_s[k+1] <= {quot_s[k][N-2:0], ge};
			end
		end
	end

	assign quot = quot_s[N];

endmodule

// File: rtl/quaternion_to_rotation_gradient_core.sv
// ----------------------------------------------------------------------------
// Throughput: one entry per cycle unless the output stalls; the entry
//   sequencer on the input side issues the nine entries of a held quaternion.
// Reset: arst_n clears all valid bits and the sequencer; gradient_enable = 1.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_gradient_core: quaternion to rotation matrix
// Emits the nine entries N/ss of the rotation matrix of a non-unit quaternion,
// each with its four partial derivatives, through a stall-all pipeline.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_gradient_core (
	input  logic        clk,
	input  logic        arst_n,
	q2r_quat_if.sink    quat,
	q2r_entry_if.source mat,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import q2r_pkg::*;

	// ---------------------------------------------------------------- config
	logic gen_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GRAD_EN) ? {31'b0, gen_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2] == REG_GRAD_EN) begin
			gen_q <= pwdata[0];
		end
	end

	// ---------------------------------------------------------------- stall
	// Whole pipeline moves together; it only holds when the output register
	// is full and not being taken.
	logic out_v_q;
	logic adv;

	assign adv = !out_v_q || mat.ready;

	// ---------------------------------------------------------------- sequencer
	// Holds one quaternion and walks the entry counter 0..8. The next
	// quaternion is taken in the cycle the ninth entry issues.
	logic                 hold_v_q;
	logic [ENT_W-1:0]     ent_q;
	logic signed [QW-1:0] hold_c_q [4];

	assign quat.ready = adv && (!hold_v_q || ent_q == LAST_ENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			ent_q    <= '0;
		end else if (adv) begin
			if (!hold_v_q || ent_q == LAST_ENT) begin
				hold_v_q <= quat.valid;
				ent_q    <= '0;
			end else begin
				ent_q <= ent_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (quat.valid && quat.ready) begin
			hold_c_q[0] <= quat.quat_x;
			hold_c_q[1] <= quat.quat_y;
			hold_c_q[2] <= quat.quat_z;
			hold_c_q[3] <= quat.quat_w;
		end
	end

	// ---------------------------------------------------------------- s1
	// Derivatives d_j = +/-2*c_k straight from the entry table, and squares.
	logic                 v_s1;
	meta_t                meta_s1;
	logic signed [QW-1:0] c_s1  [4];
	logic signed [17:0]   d_s1  [4];
	logic signed [31:0]   sq_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= hold_v_q;
	end

	for (genvar j = 0; j < 4; j++) begin : g_s1
		logic signed [QW-1:0] src;
		logic signed [17:0]   dbl;

		assign src = hold_c_q[DSEL[ent_q][j]];
		assign dbl = {src[QW-1], src, 1'b0};

		always_ff @(posedge clk) begin
			if (adv) begin
				c_s1[j]  <= hold_c_q[j];
				d_s1[j]  <= DNEG[ent_q][j] ? -dbl : dbl;
				sq_s1[j] <= hold_c_q[j] * hold_c_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.row  <= ROW_OF[ent_q];
			meta_s1.col  <= COL_OF[ent_q];
			meta_s1.last <= (ent_q == LAST_ENT);
		end
	end

	// ---------------------------------------------------------------- s2
	// N is quadratic, so sum_j c_j * dN/dc_j = 2N (Euler).
	logic                 v_s2;
	meta_t                meta_s2;
	logic signed [QW-1:0] c_s2    [4];
	logic signed [17:0]   d_s2    [4];
	logic signed [33:0]   prod_s2 [4];
	logic [32:0]          s_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	for (genvar j = 0; j < 4; j++) begin : g_s2
		always_ff @(posedge clk) begin
			if (adv) begin
				c_s2[j]    <= c_s1[j];
				d_s2[j]    <= d_s1[j];
				prod_s2[j] <= c_s1[j] * d_s1[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_s1;
			s_s2    <= {2'b0, sq_s1[0][30:0]} + {2'b0, sq_s1[1][30:0]}
				+ {2'b0, sq_s1[2][30:0]} + {2'b0, sq_s1[3][30:0]};
		end
	end

	// ---------------------------------------------------------------- s3
	logic                 v_s3;
	meta_t                meta_s3;
	logic signed [QW-1:0] c_s3 [4];
	logic signed [17:0]   d_s3 [4];
	logic [32:0]          s_s3;
	logic signed [33:0]   n_s3;
	logic                 zero_s3;
	logic signed [35:0]   psum;

	assign psum = 36'(prod_s2[0]) + 36'(prod_s2[1]) + 36'(prod_s2[2]) + 36'(prod_s2[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= meta_s2;
			c_s3    <= c_s2;
			d_s3    <= d_s2;
			s_s3    <= s_s2;
			n_s3    <= psum[34:1];
			zero_s3 <= (s_s2 == '0);
		end
	end

	// ---------------------------------------------------------------- s4
	// d*ss, c*N and the two halves of ss^2.
	logic               v_s4;
	meta_t              meta_s4;
	logic signed [51:0] ds_s4 [4];
	logic signed [49:0] cn_s4 [4];
	logic [49:0]        pplo_s4;
	logic [48:0]        pphi_s4;
	logic [32:0]        s_s4;
	logic signed [33:0] n_s4;
	logic               zero_s4;
	logic [49:0]        pplo_c;
	logic [48:0]        pphi_c;

	assign pplo_c = s_s3[16:0] * s_s3;
	assign pphi_c = s_s3[32:17] * s_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	for (genvar j = 0; j < 4; j++) begin : g_s4
		always_ff @(posedge clk) begin
			if (adv) begin
				ds_s4[j] <= d_s3[j] * $signed({1'b0, s_s3});
				cn_s4[j] <= c_s3[j] * n_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= meta_s3;
			pplo_s4 <= pplo_c;
			pphi_s4 <= pphi_c;
			s_s4    <= s_s3;
			n_s4    <= n_s3;
			zero_s4 <= zero_s3;
		end
	end

	// ---------------------------------------------------------------- s5
	// Gradient numerator m = d*ss - 2*c*N, over ss^2.
	logic               v_s5;
	meta_t              meta_s5;
	logic signed [52:0] m_s5 [4];
	logic [65:0]        s2_s5;
	logic [32:0]        s_s5;
	logic [33:0]        nmag_s5;
	logic               rneg_s5;
	logic               zero_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	for (genvar j = 0; j < 4; j++) begin : g_s5
		always_ff @(posedge clk) begin
			if (adv) m_s5[j] <= 53'(ds_s4[j]) - (53'(cn_s4[j]) <<< 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s5 <= meta_s4;
			s2_s5   <= 66'(pplo_s4) + (66'(pphi_s4) << 17);
			s_s5    <= s_s4;
			nmag_s5 <= n_s4[33] ? 34'(-n_s4) : 34'(n_s4);
			rneg_s5 <= n_s4[33];
			zero_s5 <= zero_s4;
		end
	end

	// ---------------------------------------------------------------- s6
	logic        v_s6;
	meta_t       meta_s6;
	logic [51:0] a_s6 [4];
	logic [3:0]  gneg_s6;
	logic [65:0] s2_s6;
	logic [32:0] s_s6;
	logic [33:0] nmag_s6;
	logic        rneg_s6;
	logic        zero_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	for (genvar j = 0; j < 4; j++) begin : g_s6
		always_ff @(posedge clk) begin
			if (adv) begin
				a_s6[j]    <= m_s5[j][52] ? 52'(-m_s5[j]) : 52'(m_s5[j]);
				gneg_s6[j] <= m_s5[j][52];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s6 <= meta_s5;
			s2_s6   <= s2_s5;
			s_s6    <= s_s5;
			nmag_s6 <= nmag_s5;
			rneg_s6 <= rneg_s5;
			zero_s6 <= zero_s5;
		end
	end

	// ---------------------------------------------------------------- dividers
	// Gradient: q = floor(|m| * 2^31 / ss^2), 25 bits. The dividend bits above the
	// 25 zero tail bits give the start remainder |m| << 6; when that is not below
	// ss^2 the quotient overflows and the gradient saturates.
	// Rotation: q = floor(|N| * 2^15 / ss), start remainder |N| >> 10 with the
	// low ten bits of |N| as tail.
	side_t             side_s [DIV_N+1];
	logic [DIV_N-1:0]  gquot  [4];
	logic [DIV_N-1:0]  rquot;
	logic [GDIV_W-1:0] grem_in [4];
	logic [3:0]        ovf_c;

	for (genvar j = 0; j < 4; j++) begin : g_gdiv
		assign grem_in[j] = GDIV_W'({a_s6[j], 6'b0});

		q2r_div #(.W(GDIV_W), .N(DIV_N)) u_gdiv (
			.clk     (clk),
			.adv     (adv),
			.rem_in  (grem_in[j]),
			.tail_in ('0),
			.den_in  (s2_s6),
			.quot    (gquot[j])
		);

		assign ovf_c[j] = (grem_in[j] >= s2_s6);
	end

	q2r_div #(.W(RDIV_W), .N(DIV_N)) u_rdiv (
		.clk     (clk),
		.adv     (adv),
		.rem_in  (RDIV_W'(nmag_s6 >> 10)),
		.tail_in ({nmag_s6[9:0], 15'b0}),
		.den_in  (RDIV_W'(s_s6)),
		.quot    (rquot)
	);

	assign side_s[0] = '{valid: v_s6, meta: meta_s6, zero: zero_s6, rneg: rneg_s6,
		gneg: gneg_s6, ovf: ovf_c};

	// sideband rides alongside the divider stages
	for (genvar k = 0; k < DIV_N; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_s[k+1] <= '0;
			else if (adv) side_s[k+1] <= side_s[k];
		end
	end

	// ---------------------------------------------------------------- output
	// Round half up on magnitudes, then sign; gradients saturate to Q8.16.
	side_t                sd;
	logic [16:0]          rsum;
	logic [QW-1:0]        rmag;
	logic signed [QW-1:0] rot_c;
	logic signed [GW-1:0] grad_c [4];

	assign sd    = side_s[DIV_N];
	assign rsum  = 17'(rquot[15:0]) + 17'd1;
	assign rmag  = rsum[16:1];
	assign rot_c = sd.zero ? '0 : (sd.rneg ? -$signed(rmag) : $signed(rmag));

	for (genvar j = 0; j < 4; j++) begin : g_round
		logic [25:0]   gsum;
		logic [24:0]   gm;
		logic [GW-1:0] gpos;
		logic [GW-1:0] gneg_v;

		assign gsum   = 26'(gquot[j]) + 26'd1;
		assign gm     = gsum[25:1];
		assign gpos   = (sd.ovf[j] || gm > 25'd8388607) ? 24'h7FFFFF : gm[23:0];
		assign gneg_v = (sd.ovf[j] || gm > 25'd8388608) ? 24'h800000 : 24'(25'd0 - gm);
		assign grad_c[j] = (sd.zero || !gen_q) ? '0
			: (sd.gneg[j] ? $signed(gneg_v) : $signed(gpos));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= sd.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mat.row_index  <= sd.meta.row;
			mat.col_index  <= sd.meta.col;
			mat.last_entry <= sd.meta.last;
			mat.zero_norm  <= sd.zero;
			mat.rot_entry  <= rot_c;
			mat.grad_x     <= grad_c[0];
			mat.grad_y     <= grad_c[1];
			mat.grad_z     <= grad_c[2];
			mat.grad_w     <= grad_c[3];
		end
	end

	assign mat.valid = out_v_q;

endmodule
